[rtl/srec_pkg.sv]
// Shared constants and the line summary word for the S-record line checker.
`default_nettype none
package srec_pkg;

    localparam int MAX_LINE_CHARS = 1024;
    localparam int POS_W          = $clog2(MAX_LINE_CHARS + 1);
    localparam int CMP_W          = (POS_W > 9) ? POS_W : 9;
    localparam int COUNT_BITS     = 24;
    localparam int FIELD_W        = 24;
    localparam int DATA_LINES_W   = 24;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QA_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] BYTE_TOP = 8'hFF;
    localparam logic [3:0] TEN      = 4'd10;

    // One finished line as handed from the front to the back.
    typedef struct packed {
        logic [3:0]         record_type;
        logic               type_valid;
        logic               hex_ok;
        logic               byte_count_ok;
        logic               checksum_ok;
        logic               count_record;
        logic               count_pre;    // count_ok before the counter compare
        logic               data_line;    // S1/S2/S3 line
        logic               clear_count;  // file_start seen since last line end
        logic [FIELD_W-1:0] count_field;
    } t_line_sum;

endpackage
`default_nettype wire

[rtl/srec_front.sv]
// Front end: per-character line tracking, emits one summary word per line.
`default_nettype none
module srec_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire [7:0]             i_char,
    input  wire                   i_last,
    input  wire                   i_file_start,
    input  wire                   i_q_full,
    output logic                  o_push,
    output srec_pkg::t_line_sum   o_sum
);
    import srec_pkg::*;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [3:0]         r_type_digit, n_type_digit;
    logic               r_type_good, n_type_good;
    logic [3:0]         r_high, n_high;
    logic [7:0]         r_byte_sum, n_byte_sum;
    logic [7:0]         r_last_byte, n_last_byte;
    logic [7:0]         r_decl, n_decl;
    logic               r_all_hex, n_all_hex;
    logic [FIELD_W-1:0] r_cfield, n_cfield;
    logic               r_cgood, n_cgood;
    logic               r_clr_pend;

    logic               acc;
    logic               is_hex;
    logic [3:0]         nib;
    logic [7:0]         byte_val;
    logic [3:0]         ndig;
    logic               too_long;
    logic [POS_W-1:0]   len;
    logic               is_count;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign o_push  = acc && i_last;

    always_comb begin
        is_hex = 1'b1;
        nib    = 4'd0;
        if (i_char >= CH_0 && i_char <= CH_9) begin
            nib = 4'(i_char - CH_0);
        end else if (i_char >= CH_UA && i_char <= CH_UF) begin
            nib = 4'(i_char - CH_UA) + TEN;
        end else if (i_char >= CH_LA && i_char <= CH_LF) begin
            nib = 4'(i_char - CH_LA) + TEN;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign byte_val = {r_high, nib};
    assign ndig     = (r_type_digit == 4'd5) ? 4'd4 : 4'd6;
    assign too_long = (r_pos >= POS_W'(MAX_LINE_CHARS));
    assign len      = r_pos + POS_W'(1);

    always_comb begin
        n_type_digit = r_type_digit;
        n_type_good  = r_type_good;
        n_high       = r_high;
        n_byte_sum   = r_byte_sum;
        n_last_byte  = r_last_byte;
        n_decl       = r_decl;
        n_all_hex    = r_all_hex;
        n_cfield     = r_cfield;
        n_cgood      = r_cgood;
        n_pos        = too_long ? r_pos : len;
        if (r_pos == POS_W'(0)) begin
            n_type_good = (i_char == CH_S);
        end else if (r_pos == POS_W'(1)) begin
            if (i_char >= CH_0 && i_char <= CH_9) begin
                n_type_digit = 4'(i_char - CH_0);
            end else begin
                n_type_good = 1'b0;
            end
        end else if (!too_long) begin
            if (!is_hex) begin
                n_all_hex = 1'b0;
            end
            if (!r_pos[0]) begin
                n_high = nib;
            end else begin
                if (r_pos == POS_W'(3)) begin
                    n_decl = n_all_hex ? byte_val : 8'd0;
                end else begin
                    n_byte_sum = r_byte_sum + r_last_byte;
                end
                n_last_byte = byte_val;
            end
            if (r_pos >= POS_W'(4) && r_pos < POS_W'(4) + POS_W'(ndig)) begin
                n_cfield = {r_cfield[FIELD_W-5:0], nib};
                if (!is_hex) begin
                    n_cgood = 1'b0;
                end
            end
        end else begin
            if (!is_hex) begin
                n_all_hex = 1'b0;
            end
        end
    end

    // Summary is taken from the state as it stands after this character.
    always_comb begin
        is_count            = n_type_good && (n_type_digit == 4'd5 || n_type_digit == 4'd6);
        o_sum.record_type   = n_type_good ? n_type_digit : 4'd0;
        o_sum.type_valid    = n_type_good;
        o_sum.hex_ok        = n_all_hex;
        o_sum.byte_count_ok = !too_long && len >= POS_W'(4) && n_decl >= 8'd3 &&
                              (CMP_W'({n_decl, 1'b0}) == CMP_W'(len - POS_W'(4)));
        o_sum.checksum_ok   = !too_long && n_all_hex && r_pos[0] && len >= POS_W'(6) &&
                              (n_last_byte == (BYTE_TOP - n_byte_sum));
        o_sum.count_record  = is_count;
        o_sum.count_pre     = is_count && !too_long && n_cgood &&
                              len >= POS_W'(4) + POS_W'(ndig);
        o_sum.data_line     = n_type_good && n_type_digit >= 4'd1 && n_type_digit <= 4'd3;
        o_sum.clear_count   = r_clr_pend || i_file_start;
        o_sum.count_field   = n_cfield;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_type_digit <= '0;
            r_type_good  <= 1'b0;
            r_high       <= '0;
            r_byte_sum   <= '0;
            r_last_byte  <= '0;
            r_decl       <= '0;
            r_all_hex    <= 1'b1;
            r_cfield     <= '0;
            r_cgood      <= 1'b1;
            r_clr_pend   <= 1'b0;
        end else if (acc) begin
            if (i_last) begin
                r_pos        <= '0;
                r_type_digit <= '0;
                r_type_good  <= 1'b0;
                r_high       <= '0;
                r_byte_sum   <= '0;
                r_last_byte  <= '0;
                r_decl       <= '0;
                r_all_hex    <= 1'b1;
                r_cfield     <= '0;
                r_cgood      <= 1'b1;
                r_clr_pend   <= 1'b0;
            end else begin
                r_pos        <= n_pos;
                r_type_digit <= n_type_digit;
                r_type_good  <= n_type_good;
                r_high       <= n_high;
                r_byte_sum   <= n_byte_sum;
                r_last_byte  <= n_last_byte;
                r_decl       <= n_decl;
                r_all_hex    <= n_all_hex;
                r_cfield     <= n_cfield;
                r_cgood      <= n_cgood;
                r_clr_pend   <= r_clr_pend || i_file_start;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/srec_queue.sv]
// Short queue of line summary words between the front and the back.
`default_nettype none
module srec_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  srec_pkg::t_line_sum   i_wdata,
    output logic                  o_full,
    input  wire                   i_pop,
    output logic                  o_valid,
    output srec_pkg::t_line_sum   o_rdata
);
    import srec_pkg::*;

    t_line_sum         r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wp;
    logic [QA_W-1:0]   r_rp;
    logic [QC_W-1:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QA_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QA_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/srec_back.sv]
// Back end: data line counter, count record compare and the output register.
`default_nettype none
module srec_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_q_valid,
    input  srec_pkg::t_line_sum   i_sum,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [39:0]           o_data
);
    import srec_pkg::*;

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] cnt_base;
    logic [COUNT_BITS-1:0] n_count;
    logic                  count_ok;
    logic                  r_valid;
    logic [39:0]           r_data;

    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // file_start anywhere in the line clears before the line-end increment
    assign cnt_base = i_sum.clear_count ? '0 : r_count;
    assign n_count  = (i_sum.data_line && cnt_base != {COUNT_BITS{1'b1}}) ?
                      cnt_base + COUNT_BITS'(1) : cnt_base;
    assign count_ok = i_sum.count_pre && (COUNT_BITS'(i_sum.count_field) == n_count);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= {6'd0, n_count[DATA_LINES_W-1:0], count_ok, i_sum.count_record,
                       i_sum.checksum_ok, i_sum.byte_count_ok, i_sum.hex_ok,
                       i_sum.type_valid, i_sum.record_type};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/srec_line_checker.sv]
// Top level of the S-record line checker.
//
// Input stream: one ASCII character per word on i_s_tdata, the line's final
// character marked by i_s_tlast (no newline is sent). i_s_tuser set on any
// character clears the S1/S2/S3 data line counter ahead of that character.
// Output stream: one result word per line, after the word carrying tlast.
// Throughput: one character per cycle, sustained; o_s_tready drops only when
// the two-entry line summary queue is full, which happens only when the
// receiver stalls for more than about two lines' worth of line ends.
// Result path: the edge that accepts the line's last character writes its
// summary into the queue; the output register that drives o_m_tvalid loads
// it from the queue once that register is free.
// While o_m_tready is low the result holds; the front keeps taking characters
// until the queue fills.
// Reset (synchronous, active low): clears line tracking, the queue, the data
// line counter and the output valid. Lines longer than 1024 characters fail
// the byte count and checksum checks.
`default_nettype none
module srec_line_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [7:0]   i_s_tdata,   // [7:0] char_code
    input  wire         i_s_tlast,   // line_last
    input  wire         i_s_tuser,   // file_start
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [3:0] record_type, [4] type_valid, [5] hex_ok, [6] byte_count_ok,
    // [7] checksum_ok, [8] count_record, [9] count_ok, [33:10] data_lines
    output logic [39:0] o_m_tdata
);
    import srec_pkg::*;

    t_line_sum front_sum;
    t_line_sum queue_sum;
    logic      push;
    logic      q_full;
    logic      q_valid;
    logic      pop;

    srec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_char       (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_file_start (i_s_tuser),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_sum        (front_sum)
    );

    srec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_sum),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rdata (queue_sum)
    );

    srec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_sum     (queue_sum),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata)
    );

endmodule
`default_nettype wire
